>>> rtl/core/sph_poly6_density_accumulator_assert.svh
// assertion macros shared by the checkers of the density accumulator
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef SPH_POLY6_DENSITY_ACCUMULATOR_ASSERT_SVH
`define SPH_POLY6_DENSITY_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, masked while in reset
`define SPHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define SPHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, checked during reset too
`define SPHD_ASSERT_NEXT_ANY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sphd_pkg.sv
// types and constants of the poly6 density accumulator
// no dependencies; imported by every module of the block
`default_nettype none

package sphd_pkg;

    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam int unsigned POS_W   = 24;
    localparam int unsigned RAD_W   = 40;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned Q_W     = 32;
    localparam int unsigned D_W     = RAD_W - 16;

    // configuration register indexes
    localparam logic CFG_RADIUS_SQ    = 1'b0;
    localparam logic CFG_KERNEL_SCALE = 1'b1;

    typedef struct packed {
        logic [RAD_W-1:0]   radius_sq;
        logic [SCALE_W-1:0] kernel_scale;
    } t_sphd_cfg;

    // one classified item waiting for the kernel unit
    typedef struct packed {
        logic           first;
        logic           add;
        logic           last;
        logic [D_W-1:0] d;
    } t_sphd_entry;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_CUBE,
        B_SCALE,
        B_ADD,
        B_EMIT
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/core/sph_poly6_density_accumulator.sv
// path: an input transaction passes front stages 1 to 3 and is written into the queue; the
// kernel unit pops each item in B_IDLE, runs B_SQ, B_CUBE, B_SCALE and B_ADD per in-range
// neighbour and for a particle's self term, and loads the output register in B_EMIT when the item is marked last
// the kernel unit's shared 32x32 multiplier limits the rate; it finishes each item before popping the next
// reset: synchronous active low; clears queue, pipe valids, fsm, output valid and both
// config registers; the first item after reset starts a new particle
`default_nettype none

module sph_poly6_density_accumulator
    import sphd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    // own_x[23:0], own_y[47:24], own_z[71:48], nbr_x[95:72], nbr_y[119:96], nbr_z[143:120]
    input  wire logic [6*POS_W-1:0]   s_axis_tdata,
    // nbr_valid[0]
    input  wire logic [0:0]           s_axis_tuser,
    // last
    input  wire logic                 s_axis_tlast,
    // result stream
    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // density[31:0]
    output      logic [Q_W-1:0]       m_axis_tdata,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [RAD_W-1:0]     i_cfg_data
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [RAD_W-1:0]   r_radius_sq;
    logic [SCALE_W-1:0] r_kernel_scale;
    t_sphd_cfg          cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq    <= '0;
            r_kernel_scale <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS_SQ:    r_radius_sq    <= i_cfg_data;
                CFG_KERNEL_SCALE: r_kernel_scale <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.radius_sq    = r_radius_sq;
    assign cfg.kernel_scale = r_kernel_scale;

    // front to back queue
    logic              push, pop, head_valid;
    t_sphd_entry       push_entry, head;
    logic [QCW-1:0]    q_count;

    // front: differences, squares, sum, range test and kernel argument
    sphd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_nbr_valid (s_axis_tuser[0]),
        .i_last      (s_axis_tlast),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // decouples the fixed-latency front from the variable-latency kernel unit
    sphd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_count      (q_count)
    );

    // back: self term seeding, cubing and scaling, saturating sum, result transaction
    sphd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_density    (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/sphd_queue.sv
// small flip-flop queue between the distance front end and the kernel unit
// depends on sphd_pkg
`default_nettype none

module sphd_queue
    import sphd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_sphd_entry       i_entry,
    input  logic              i_pop,
    output logic              o_head_valid,
    output t_sphd_entry       o_head,
    output logic [QCW-1:0]    o_count
);

    t_sphd_entry          r_mem [QDEPTH];
    logic [QAW-1:0]       r_wr;
    logic [QAW-1:0]       r_rd;
    logic [QCW-1:0]       r_count;
    logic [QCW-1:0]       n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = (r_count != '0);
    assign o_count      = r_count;

endmodule

`default_nettype wire

>>> rtl/core/sphd_front.sv
// front end: takes items, computes squared distance and classifies each item
// depends on sphd_pkg; feeds sphd_queue
`default_nettype none

module sphd_front
    import sphd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sphd_cfg            i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [6*POS_W-1:0]   i_data,
    input  logic                 i_nbr_valid,
    input  logic                 i_last,
    input  logic [QCW-1:0]       i_q_count,
    output logic                 o_push,
    output t_sphd_entry          o_entry
);

    logic signed [POS_W-1:0] own_x, own_y, own_z, nbr_x, nbr_y, nbr_z;
    logic                    accept;

    // stage 1: coordinate differences
    logic                    r_v1, r_nv1, r_last1, r_first1;
    logic signed [POS_W:0]   r_dx, r_dy, r_dz;
    // stage 2: squares
    logic                    r_v2, r_nv2, r_last2, r_first2;
    logic [2*POS_W:0]        r_sx, r_sy, r_sz;
    // stage 3: sum of squares
    logic                    r_v3, r_nv3, r_last3, r_first3;
    logic [2*POS_W+1:0]      r_r2;

    logic                    r_start;
    logic [QCW-1:0]          occupied;
    logic signed [2*POS_W+1:0] sq_x, sq_y, sq_z;
    logic                    in_range;

    assign own_x = i_data[0*POS_W +: POS_W];
    assign own_y = i_data[1*POS_W +: POS_W];
    assign own_z = i_data[2*POS_W +: POS_W];
    assign nbr_x = i_data[3*POS_W +: POS_W];
    assign nbr_y = i_data[4*POS_W +: POS_W];
    assign nbr_z = i_data[5*POS_W +: POS_W];

    // room is reserved for every item still in the pipe
    assign occupied = i_q_count + QCW'(r_v1) + QCW'(r_v2) + QCW'(r_v3);
    assign o_ready  = (occupied < QCW'(QDEPTH));
    assign accept   = i_valid && o_ready;

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign sq_z = r_dz * r_dz;

    assign in_range = (r_r2 <= {{(2*POS_W+2-RAD_W){1'b0}}, i_cfg.radius_sq});

    always_comb begin
        o_push        = r_v3;
        o_entry.first = r_first3;
        o_entry.last  = r_last3;
        o_entry.add   = r_nv3 && in_range;
        o_entry.d     = i_cfg.radius_sq[RAD_W-1:16] - r_r2[RAD_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_start <= 1'b1;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (accept) begin
                r_start <= i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= {own_x[POS_W-1], own_x} - {nbr_x[POS_W-1], nbr_x};
        r_dy     <= {own_y[POS_W-1], own_y} - {nbr_y[POS_W-1], nbr_y};
        r_dz     <= {own_z[POS_W-1], own_z} - {nbr_z[POS_W-1], nbr_z};
        r_nv1    <= i_nbr_valid;
        r_last1  <= i_last;
        r_first1 <= r_start;

        r_sx     <= sq_x[2*POS_W:0];
        r_sy     <= sq_y[2*POS_W:0];
        r_sz     <= sq_z[2*POS_W:0];
        r_nv2    <= r_nv1;
        r_last2  <= r_last1;
        r_first2 <= r_first1;

        r_r2     <= {1'b0, r_sx} + {1'b0, r_sy} + {1'b0, r_sz};
        r_nv3    <= r_nv2;
        r_last3  <= r_last2;
        r_first3 <= r_first2;
    end

endmodule

`default_nettype wire

>>> rtl/core/sphd_back.sv
// back end: kernel unit with one shared multiplier, accumulator and output register
// depends on sphd_pkg; drained from sphd_queue
`default_nettype none

module sphd_back
    import sphd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sphd_cfg         i_cfg,
    input  logic              i_head_valid,
    input  t_sphd_entry       i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [Q_W-1:0]    o_density
);

    t_back_state      r_state, n_state;
    logic             r_self, n_self;
    logic             r_add, n_add;
    logic             r_last, n_last;
    logic [D_W-1:0]   r_md, n_md;
    logic [D_W-1:0]   r_nd, n_nd;
    logic [Q_W-1:0]   r_p, n_p;
    logic [Q_W-1:0]   r_sum, n_sum;
    logic             r_ovalid, n_ovalid;
    logic [Q_W-1:0]   r_odata, n_odata;

    logic [Q_W-1:0]   mul_a, mul_b;
    logic [2*Q_W-1:0] prod;
    logic [Q_W-1:0]   prod_sat;
    logic [Q_W:0]     sum_ext;

    // shared multiplier: d*d, p*d, p*scale
    assign mul_a = (r_state == B_SQ) ? {{(Q_W-D_W){1'b0}}, r_md} : r_p;
    assign mul_b = (r_state == B_SCALE) ? i_cfg.kernel_scale
                                        : {{(Q_W-D_W){1'b0}}, r_md};
    assign prod  = mul_a * mul_b;
    assign prod_sat = (|prod[2*Q_W-1:Q_W+16]) ? '1 : prod[Q_W+15:16];
    assign sum_ext  = {1'b0, r_sum} + {1'b0, r_p};

    always_comb begin
        n_state  = r_state;
        n_self   = r_self;
        n_add    = r_add;
        n_last   = r_last;
        n_md     = r_md;
        n_nd     = r_nd;
        n_p      = r_p;
        n_sum    = r_sum;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        o_pop    = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (i_head_valid) begin
                    o_pop  = 1'b1;
                    n_add  = i_head.add;
                    n_last = i_head.last;
                    n_nd   = i_head.d;
                    if (i_head.first) begin
                        n_self  = 1'b1;
                        n_md    = i_cfg.radius_sq[RAD_W-1:16];
                        n_state = B_SQ;
                    end else if (i_head.add) begin
                        n_self  = 1'b0;
                        n_md    = i_head.d;
                        n_state = B_SQ;
                    end else if (i_head.last) begin
                        n_state = B_EMIT;
                    end
                end
            end
            B_SQ: begin
                n_p     = prod_sat;
                n_state = B_CUBE;
            end
            B_CUBE: begin
                n_p     = prod_sat;
                n_state = B_SCALE;
            end
            B_SCALE: begin
                n_p     = prod_sat;
                n_state = B_ADD;
            end
            B_ADD: begin
                if (r_self) begin
                    n_sum = r_p;
                end else begin
                    n_sum = sum_ext[Q_W] ? '1 : sum_ext[Q_W-1:0];
                end
                if (r_self && r_add) begin
                    n_self  = 1'b0;
                    n_md    = r_nd;
                    n_state = B_SQ;
                end else if (r_last) begin
                    n_state = B_EMIT;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_sum;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_self  <= n_self;
        r_add   <= n_add;
        r_last  <= n_last;
        r_md    <= n_md;
        r_nd    <= n_nd;
        r_p     <= n_p;
        r_sum   <= n_sum;
        r_odata <= n_odata;
    end

    assign o_valid   = r_ovalid;
    assign o_density = r_odata;

endmodule

`default_nettype wire

>>> rtl/core/sphd_checker.sv
// port-level checker for the density accumulator, bound to the top level
// depends on sphd_pkg and sph_poly6_density_accumulator_assert.svh
`default_nettype none

`include "sph_poly6_density_accumulator_assert.svh"

module sphd_checker
    import sphd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [Q_W-1:0]       m_axis_tdata
);

    // particles closed on the input side but not yet delivered
    logic [4:0] r_pending, n_pending;
    logic       in_last, out_take;

    assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_take = m_axis_tvalid && m_axis_tready;

    always_comb begin
        n_pending = r_pending;
        if (in_last && !out_take) begin
            n_pending = r_pending + 5'd1;
        end else if (!in_last && out_take) begin
            n_pending = r_pending - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `SPHD_ASSERT_NOW(a_no_invented_result, m_axis_tvalid, r_pending != 5'd0,
        "result without a closed particle")
    `SPHD_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `SPHD_ASSERT_NEXT_ANY(a_reset_clears_out, !i_rst_n, !m_axis_tvalid,
        "result valid after reset")

endmodule

bind sph_poly6_density_accumulator sphd_checker u_sphd_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the poly6 density accumulator
// depends on sphd_pkg and sph_poly6_density_accumulator from rtl/core
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sphd_pkg::*;

    // run length and timing
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int SETTLE       = 4 + 9 * (QDEPTH + 2) + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    // one particle/neighbour pair as it travels on the input stream
    typedef struct {
        logic signed [POS_W-1:0] own_x;
        logic signed [POS_W-1:0] own_y;
        logic signed [POS_W-1:0] own_z;
        logic signed [POS_W-1:0] nbr_x;
        logic signed [POS_W-1:0] nbr_y;
        logic signed [POS_W-1:0] nbr_z;
        bit                      nbr_valid;
        bit                      last;
    } t_pair;

    // predicts densities from accepted pairs and compares emitted densities
    class density_scoreboard;
        logic [RAD_W-1:0]   radius_sq;
        logic [SCALE_W-1:0] scale;
        logic [Q_W-1:0]     running_sum;
        bit                 new_particle;
        logic [Q_W-1:0]     density_q[$];
        int unsigned        items;
        int unsigned        densities;
        int unsigned        mismatches;

        function new();
            radius_sq    = '0;
            scale        = '0;
            running_sum  = '0;
            new_particle = 1'b1;
            items        = 0;
            densities    = 0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic idx, logic [RAD_W-1:0] value);
            if (idx == CFG_RADIUS_SQ)
                radius_sq = value;
            else
                scale = value[SCALE_W-1:0];
        endfunction

        // q16.16 product, truncated and clamped to 32 bits
        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
            logic [63:0] p;
            p = (a * b) >> 16;
            return (p > {32'd0, SAT}) ? {32'd0, SAT} : p;
        endfunction

        function logic [Q_W-1:0] poly6_term(logic [D_W-1:0] d);
            logic [63:0] p1;
            logic [63:0] p2;
            logic [63:0] t;
            p1 = qmul({40'd0, d}, {40'd0, d});
            p2 = qmul(p1, {40'd0, d});
            t  = qmul(p2, {32'd0, scale});
            return t[Q_W-1:0];
        endfunction

        function void note_pair(t_pair p);
            logic [D_W-1:0] h2q;
            logic [63:0]    r2;
            logic [32:0]    acc;
            longint         dx;
            longint         dy;
            longint         dz;
            items++;
            h2q = radius_sq[RAD_W-1:16];
            if (new_particle) begin
                running_sum  = poly6_term(h2q);
                new_particle = 1'b0;
            end
            if (p.nbr_valid) begin
                dx = longint'(p.own_x) - longint'(p.nbr_x);
                dy = longint'(p.own_y) - longint'(p.nbr_y);
                dz = longint'(p.own_z) - longint'(p.nbr_z);
                r2 = dx * dx + dy * dy + dz * dz;
                // within the radius: r^2 <= h^2, compared at full precision
                if (r2 <= {24'd0, radius_sq}) begin
                    acc = {1'b0, running_sum} + {1'b0, poly6_term(h2q - r2[D_W+15:16])};
                    running_sum = acc[32] ? SAT : acc[31:0];
                end
            end
            if (p.last) begin
                density_q.push_back(running_sum);
                new_particle = 1'b1;
            end
        endfunction

        function void check_density(logic [Q_W-1:0] got);
            logic [Q_W-1:0] want;
            densities++;
            if (density_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("density %h emitted with no particle outstanding", got);
            end else begin
                want = density_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("density mismatch: expected %h got %h", want, got);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // own_x, own_y, own_z, nbr_x, nbr_y, nbr_z, 24 bits each from bit 0 up
    logic [6*POS_W-1:0]   s_axis_tdata;
    // nbr_valid
    logic [0:0]           s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // density
    logic [Q_W-1:0]       m_axis_tdata;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [RAD_W-1:0]     i_cfg_data;

    density_scoreboard sb;

    // shared idling controls
    bit          quiet;       // no idling on either side
    bit          bursty;      // toggles between idling and calm stretches
    int          hold_left;   // long receiver hold-off, counted by the receiver
    int unsigned cycles;
    int unsigned settings;

    sph_poly6_density_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: ends the run once the cycle limit is reached
    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("testbench NOT OK");
        $finish;
    end

    // receiver: random stall bursts, calm stretches and one long hold-off
    initial begin : receiver
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        bursty        = 1'b1;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0)
                bursty = ~bursty;
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (!quiet && bursty && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 3);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // every density transaction goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_density(m_axis_tdata);
    end

    function automatic t_pair mk_pair(int ox, int oy, int oz, int nx, int ny, int nz,
                                      bit valid, bit last);
        t_pair p;
        p.own_x     = ox[POS_W-1:0];
        p.own_y     = oy[POS_W-1:0];
        p.own_z     = oz[POS_W-1:0];
        p.nbr_x     = nx[POS_W-1:0];
        p.nbr_y     = ny[POS_W-1:0];
        p.nbr_z     = nz[POS_W-1:0];
        p.nbr_valid = valid;
        p.last      = last;
        return p;
    endfunction

    // offers one pair and returns just after the edge that accepts it;
    // entered right after a rising edge, tvalid may still be high from the last pair
    task automatic send_pair(t_pair p);
        @(negedge i_clk);
        if (!quiet && bursty && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tdata  = {p.nbr_z, p.nbr_y, p.nbr_x, p.own_z, p.own_y, p.own_x};
        s_axis_tuser  = p.nbr_valid;
        s_axis_tlast  = p.last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_pair(p);
    endtask

    // stops offering, waits for every predicted density, then lets the kernel settle
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.density_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write; only called with the block idle
    task automatic write_reg(logic idx, logic [RAD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [RAD_W-1:0] radius, logic [SCALE_W-1:0] scale);
        write_reg(CFG_RADIUS_SQ, radius);
        write_reg(CFG_KERNEL_SCALE, {8'd0, scale});
        settings++;
    endtask

    // one particle: neighbours scattered around the owner within about 1.25 h per axis,
    // with invalid neighbours, exact overlaps, moving owners and fully random noise
    task automatic send_particle(int span);
        t_pair p;
        int    n;
        int    ox;
        int    oy;
        int    oz;
        n  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        ox = $urandom;
        oy = $urandom;
        oz = $urandom;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                ox = $urandom;
                oy = $urandom;
                oz = $urandom;
            end
            if ($urandom_range(0, 9) == 0) begin
                p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            1'($urandom_range(0, 1)), i == n - 1);
            end else if ($urandom_range(0, 15) == 0) begin
                p = mk_pair(ox, oy, oz, ox, oy, oz, 1'b1, i == n - 1);
            end else begin
                p = mk_pair(ox, oy, oz,
                            ox + int'($urandom_range(0, 2 * span)) - span,
                            oy + int'($urandom_range(0, 2 * span)) - span,
                            oz + int'($urandom_range(0, 2 * span)) - span,
                            $urandom_range(0, 11) != 0, i == n - 1);
            end
            send_pair(p);
        end
    endtask

    initial begin : stimulus
        longint           h;
        int               span;
        int unsigned      goal;
        int unsigned      leftover;
        logic [SCALE_W-1:0] scale;

        sb            = new();
        quiet         = 1'b0;
        hold_left     = 0;
        settings      = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_RADIUS_SQ;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // registers still at reset: zero radius and scale, density zero
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        drain_results();

        // h = 1.0, scale = 1.0
        set_regs(40'h01_0000_0000, 32'h0001_0000);
        // single pair particle: self term plus a coincident neighbour
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        // neighbour exactly on the radius, then one step beyond it
        send_pair(mk_pair(0, 0, 0, 32'h1_0000, 0, 0, 1'b1, 1'b1));
        send_pair(mk_pair(0, 0, 0, 32'h1_0001, 0, 0, 1'b1, 1'b1));
        // invalid neighbour with junk positions still emits the self term
        send_pair(mk_pair(0, 0, 0, 8388607, -8388608, 8388607, 1'b0, 1'b1));
        // multi pair particle over the position extremes, owner moving inside it
        send_pair(mk_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                          1'b1, 1'b0));
        send_pair(mk_pair(8388607, 8388607, 8388607, 8388607 - 32'h4000, 8388607,
                          8388607 - 32'h8000, 1'b1, 1'b0));
        send_pair(mk_pair(32'h123456, -32'h6543, 32'h7FF00, 0, 0, 0, 1'b0, 1'b0));
        send_pair(mk_pair(-1, -1, -1, 0, 0, 0, 1'b1, 1'b1));
        // scale rewritten in the middle of a particle
        send_pair(mk_pair(0, 0, 0, 32'h8000, 0, 0, 1'b1, 1'b0));
        drain_results();
        write_reg(CFG_KERNEL_SCALE, 40'h00_0003_0000);
        send_pair(mk_pair(0, 0, 0, 0, 32'h8000, 32'h8000, 1'b1, 1'b1));
        drain_results();

        // everything at maximum: products and sum saturate
        set_regs(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(mk_pair(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        send_pair(mk_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                          1'b1, 1'b1));
        send_pair(mk_pair(5, 7, 9, 5, 7, 9, 1'b1, 1'b0));
        send_pair(mk_pair(5, 7, 9, 6, 7, 9, 1'b1, 1'b1));
        drain_results();
        // zero scale with a wide radius
        set_regs(40'hFF_FFFF_FFFF, 32'h0000_0000);
        send_pair(mk_pair(1, 2, 3, 1, 2, 3, 1'b1, 1'b1));
        drain_results();

        // random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            quiet = (phase == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       scale = $urandom_range(1, 32'h1_0000);
                1:       scale = $urandom_range(32'h1_0000, 32'h4_0000);
                default: scale = $urandom;
            endcase
            if (phase == 0) begin
                // zero radius: only exact overlaps count
                set_regs('0, 32'hFFFF_FFFF);
                span = 4;
            end else if (phase == 1) begin
                set_regs(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
                span = 1 << 20;
            end else begin
                h = $urandom_range(1 << 10, (1 << 20) - 1);
                set_regs(RAD_W'(h * h + $urandom_range(0, 32'(2 * h))), scale);
                span = int'(h) + int'(h) / 4;
            end
            // the receiver holds off while the sender keeps offering
            if (phase == 2)
                hold_left = HOLD_CYCLES;
            goal = sb.items + PHASE_ITEMS;
            while (sb.items < goal)
                send_particle(span);
            drain_results();
        end

        leftover = sb.density_q.size();
        if (leftover != 0)
            $display("%0d predicted densities never emitted", leftover);
        $display("ran %0d pair transactions under %0d register settings",
                 sb.items, settings);
        $display("checked %0d densities, %0d mismatches", sb.densities, sb.mismatches);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
